// ===== rtl/speech_segment_endpointer_top_macros.svh =====
// Assertion macros used by the endpointer's port checker.
`ifndef SPEECH_SEGMENT_ENDPOINTER_TOP_MACROS_SVH
`define SPEECH_SEGMENT_ENDPOINTER_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define SSE_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("endpointer check failed");

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define SSE_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("endpointer check failed");

`endif

// ===== rtl/sse_pkg.sv =====
// Shared types, codes and constants of the speech segment endpointer.
package sse_pkg;

	// samples per analysis window
	localparam int unsigned WINDOW_SAMPLES = 512;

	// input command codes
	localparam logic [1:0] CMD_WINDOW = 2'd0;
	localparam logic [1:0] CMD_END    = 2'd1;
	localparam logic [1:0] CMD_RESET  = 2'd2;

	// result kinds
	localparam logic [1:0] KIND_PARTIAL = 2'd0;
	localparam logic [1:0] KIND_FINAL   = 2'd1;
	localparam logic [1:0] KIND_DISCARD = 2'd2;

	// configuration port
	localparam int unsigned CFG_IDX_W  = 8;
	localparam int unsigned CFG_DATA_W = 24;

	localparam logic [CFG_IDX_W-1:0] REG_VOICE_LEVEL        = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_SPEECH_SAMPLES = 8'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ENDPOINT_SILENCE   = 8'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PRE_ROLL_LEN       = 8'd3;
	localparam logic [CFG_IDX_W-1:0] REG_POST_ROLL_LEN      = 8'd4;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_SEGMENT_LEN    = 8'd5;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_PARTIAL_LEN    = 8'd6;
	localparam logic [CFG_IDX_W-1:0] REG_PARTIAL_CADENCE    = 8'd7;

	typedef struct packed {
		logic [15:0] voice_level;
		logic [23:0] min_speech_samples;
		logic [23:0] endpoint_silence;
		logic [23:0] pre_roll_len;
		logic [23:0] post_roll_len;
		logic [23:0] max_segment_len;
		logic [23:0] min_partial_len;
		logic [23:0] partial_cadence;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		voice_level:        16'd32768,
		min_speech_samples: 24'd4000,
		endpoint_silence:   24'd8000,
		pre_roll_len:       24'd4800,
		post_roll_len:      24'd3200,
		max_segment_len:    24'd480000,
		min_partial_len:    24'd16000,
		partial_cadence:    24'd8000
	};

	// one result item
	typedef struct packed {
		logic [1:0]  request_kind;
		logic [31:0] segment_number;
		logic [47:0] span_first;
		logic [47:0] span_limit;
		logic        last;
	} res_t;

	// results of one processed item, handed to the output buffer
	typedef struct packed {
		logic [1:0] count;
		res_t       r0;
		res_t       r1;
	} push_t;

endpackage

// ===== rtl/sse_ifs.sv =====
// Channel interfaces: analysis windows in, requests out, register writes.
interface sse_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  command;
	logic [15:0] speech_probability;
	logic [47:0] win_origin;

	modport source(output valid, output command, output speech_probability,
		output win_origin, input ready);
	modport sink(input valid, input command, input speech_probability,
		input win_origin, output ready);
endinterface

interface sse_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  request_kind;
	logic [31:0] segment_number;
	logic [47:0] span_first;
	logic [47:0] span_limit;
	logic        last;

	modport source(output valid, output request_kind, output segment_number,
		output span_first, output span_limit, output last, input ready);
	modport sink(input valid, input request_kind, input segment_number,
		input span_first, input span_limit, input last, output ready);
endinterface

interface sse_cfg_if;
	logic                             valid;
	logic                             ready;
	logic [sse_pkg::CFG_IDX_W-1:0]  index;
	logic [sse_pkg::CFG_DATA_W-1:0] data;

	modport source(output valid, output index, output data, input ready);
	modport sink(input valid, input index, input data, output ready);
endinterface

// ===== rtl/sse_cfg_regs.sv =====
// Configuration register file of the endpointer.
module sse_cfg_regs (
	input  logic          clk,
	input  logic          arst_n,
	sse_cfg_if.sink       wr,
	output sse_pkg::cfg_t regs
);

	sse_pkg::cfg_t regs_q;

	assign wr.ready = 1'b1;
	assign regs     = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q <= sse_pkg::CFG_RESET;
		end else if (wr.valid) begin
			unique case (wr.index)
				sse_pkg::REG_VOICE_LEVEL:        regs_q.voice_level        <= wr.data[15:0];
				sse_pkg::REG_MIN_SPEECH_SAMPLES: regs_q.min_speech_samples <= wr.data;
				sse_pkg::REG_ENDPOINT_SILENCE:   regs_q.endpoint_silence   <= wr.data;
				sse_pkg::REG_PRE_ROLL_LEN:       regs_q.pre_roll_len       <= wr.data;
				sse_pkg::REG_POST_ROLL_LEN:      regs_q.post_roll_len      <= wr.data;
				sse_pkg::REG_MAX_SEGMENT_LEN:    regs_q.max_segment_len    <= wr.data;
				sse_pkg::REG_MIN_PARTIAL_LEN:    regs_q.min_partial_len    <= wr.data;
				sse_pkg::REG_PARTIAL_CADENCE:    regs_q.partial_cadence    <= wr.data;
				default: ;
			endcase
		end
	end

endmodule

// ===== rtl/sse_core.sv =====
// Input register and single-pass segment tracking logic.
module sse_core (
	input  logic           clk,
	input  logic           arst_n,
	sse_in_if.sink         window,
	input  sse_pkg::cfg_t  cfg,
	input  logic           room2,
	output sse_pkg::push_t push
);

	typedef struct packed {
		logic        is_open;
		logic [31:0] seg_num;
		logic [31:0] next_num;
		logic [47:0] seg_begin;
		logic [24:0] seg_len;
		logic [23:0] speech_cnt;
		logic [23:0] silence_cnt;
		logic [47:0] partial_end;
		logic [23:0] preroll_fill;
	} state_t;

	localparam state_t STATE_CLEAR = '{
		is_open:      1'b0,
		seg_num:      32'd0,
		next_num:     32'd1,
		seg_begin:    48'd0,
		seg_len:      25'd0,
		speech_cnt:   24'd0,
		silence_cnt:  24'd0,
		partial_end:  48'd0,
		preroll_fill: 24'd0
	};

	// input register
	logic        vld_s1;
	logic [1:0]  cmd_s1;
	logic [15:0] prob_s1;
	logic [47:0] wstart_s1;

	state_t st_q, st_d;
	logic   fire;

	assign fire         = vld_s1 && room2;
	assign window.ready = !vld_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (window.valid && window.ready) begin
			vld_s1 <= 1'b1;
		end else if (fire) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (window.valid && window.ready) begin
			cmd_s1    <= window.command;
			prob_s1   <= window.speech_probability;
			wstart_s1 <= window.win_origin;
		end
	end

	// window arithmetic
	logic [48:0] wend;
	logic [24:0] fill_sum;
	logic [23:0] fill_n;
	logic        is_speech, open_now, open_n;
	logic [47:0] begin_new, begin_n, lpe_base, lpe_n;
	logic [25:0] len_inc;
	logic [24:0] len_sat, len_n, len_t, close_len;
	logic [24:0] spc_inc, sil_inc;
	logic [23:0] speech_n, sil_n, excess;
	logic [31:0] num;
	logic [48:0] end_full, gap;
	logic        part, endsil, trim, close_w, discard_w, discard_e;
	logic [47:0] close_end, eos_end;
	sse_pkg::res_t part_item, close_item, eos_item;

	assign wend     = {1'b0, wstart_s1} + 49'(sse_pkg::WINDOW_SAMPLES);
	assign fill_sum = {1'b0, st_q.preroll_fill} + 25'(sse_pkg::WINDOW_SAMPLES);
	assign fill_n   = (fill_sum > {1'b0, cfg.pre_roll_len}) ? cfg.pre_roll_len
		: fill_sum[23:0];

	assign is_speech = prob_s1 >= cfg.voice_level;
	assign open_now  = !st_q.is_open && is_speech;
	assign open_n    = st_q.is_open || is_speech;

	// pre-roll start clamps at sample zero
	assign begin_new = (wend > {25'd0, fill_n}) ? 48'(wend - {25'd0, fill_n}) : '0;
	assign begin_n   = open_now ? begin_new : st_q.seg_begin;

	assign len_inc = {1'b0, st_q.seg_len} + 26'(sse_pkg::WINDOW_SAMPLES);
	assign len_sat = len_inc[25] ? '1 : len_inc[24:0];
	assign len_n   = open_now ? {1'b0, fill_n} : (st_q.is_open ? len_sat : st_q.seg_len);

	assign spc_inc  = {1'b0, st_q.speech_cnt} + 25'(sse_pkg::WINDOW_SAMPLES);
	assign speech_n = is_speech ? (spc_inc[24] ? '1 : spc_inc[23:0]) : st_q.speech_cnt;

	assign sil_inc = {1'b0, st_q.silence_cnt} + 25'(sse_pkg::WINDOW_SAMPLES);
	assign sil_n   = is_speech ? '0
		: (st_q.is_open ? (sil_inc[24] ? '1 : sil_inc[23:0]) : st_q.silence_cnt);

	assign num      = open_now ? st_q.next_num : st_q.seg_num;
	assign lpe_base = open_now ? begin_n : st_q.partial_end;

	// partial request on cadence
	assign end_full = {1'b0, begin_n} + 49'(len_n);
	assign gap      = end_full - {1'b0, lpe_base};
	assign part     = open_n && (len_n >= {1'b0, cfg.min_partial_len})
		&& (end_full >= {1'b0, lpe_base}) && (gap >= 49'(cfg.partial_cadence));
	assign lpe_n    = part ? end_full[47:0] : lpe_base;

	// close on silence endpoint (trimmed to post-roll) or on length cap
	assign endsil    = sil_n >= cfg.endpoint_silence;
	assign excess    = sil_n - cfg.post_roll_len;
	assign trim      = (sil_n > cfg.post_roll_len) && ({1'b0, excess} <= len_n);
	assign len_t     = trim ? (len_n - {1'b0, excess}) : len_n;
	assign close_w   = open_n && (endsil || (len_n >= {1'b0, cfg.max_segment_len}));
	assign close_len = endsil ? len_t : len_n;
	assign close_end = begin_n + 48'(close_len);
	assign discard_w = speech_n < cfg.min_speech_samples;

	// end of stream closes untrimmed
	assign eos_end   = st_q.seg_begin + 48'(st_q.seg_len);
	assign discard_e = st_q.speech_cnt < cfg.min_speech_samples;

	always_comb begin
		part_item.request_kind   = sse_pkg::KIND_PARTIAL;
		part_item.segment_number = num;
		part_item.span_first     = begin_n;
		part_item.span_limit     = end_full[47:0];
		part_item.last           = !close_w;

		close_item.request_kind   = discard_w ? sse_pkg::KIND_DISCARD : sse_pkg::KIND_FINAL;
		close_item.segment_number = num;
		close_item.span_first     = begin_n;
		close_item.span_limit     = close_end;
		close_item.last           = 1'b1;

		eos_item.request_kind   = discard_e ? sse_pkg::KIND_DISCARD : sse_pkg::KIND_FINAL;
		eos_item.segment_number = st_q.seg_num;
		eos_item.span_first     = st_q.seg_begin;
		eos_item.span_limit     = eos_end;
		eos_item.last           = 1'b1;
	end

	always_comb begin
		st_d       = st_q;
		push.count = 2'd0;
		push.r0    = close_item;
		push.r1    = close_item;
		case (cmd_s1)
			sse_pkg::CMD_RESET: begin
				st_d = STATE_CLEAR;
			end
			sse_pkg::CMD_END: begin
				st_d       = STATE_CLEAR;
				push.count = {1'b0, st_q.is_open};
				push.r0    = eos_item;
			end
			sse_pkg::CMD_WINDOW: begin
				st_d.preroll_fill = fill_n;
				st_d.seg_begin    = begin_n;
				st_d.seg_num      = num;
				st_d.partial_end  = lpe_n;
				if (close_w) begin
					st_d.is_open     = 1'b0;
					st_d.seg_len     = '0;
					st_d.speech_cnt  = '0;
					st_d.silence_cnt = '0;
					if (!discard_w) begin
						st_d.next_num    = num + 32'd1;
						st_d.partial_end = '0;
					end
				end else begin
					st_d.is_open     = open_n;
					st_d.seg_len     = len_n;
					st_d.speech_cnt  = speech_n;
					st_d.silence_cnt = sil_n;
				end
				push.count = {1'b0, part} + {1'b0, close_w};
				push.r0    = part ? part_item : close_item;
			end
			default: ;
		endcase
		if (!fire) begin
			st_d       = st_q;
			push.count = 2'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= STATE_CLEAR;
		end else begin
			st_q <= st_d;
		end
	end

endmodule

// ===== rtl/sse_out_buf.sv =====
// Two-entry result buffer between the tracking logic and the request channel.
module sse_out_buf (
	input  logic           clk,
	input  logic           arst_n,
	input  sse_pkg::push_t push,
	output logic           room2,
	sse_out_if.source      request
);

	sse_pkg::res_t slot0_q, slot1_q, slot0_d, slot1_d;
	logic [1:0]    occ_q, occ_d, occ_a;
	logic          pop;

	assign request.valid          = occ_q != 2'd0;
	assign request.request_kind   = slot0_q.request_kind;
	assign request.segment_number = slot0_q.segment_number;
	assign request.span_first     = slot0_q.span_first;
	assign request.span_limit     = slot0_q.span_limit;
	assign request.last           = slot0_q.last;

	assign pop   = request.valid && request.ready;
	assign room2 = (occ_q == 2'd0) || ((occ_q == 2'd1) && request.ready);

	always_comb begin
		slot0_d = slot0_q;
		slot1_d = slot1_q;
		occ_a   = occ_q;
		if (pop) begin
			slot0_d = slot1_q;
			occ_a   = occ_q - 2'd1;
		end
		case (push.count)
			2'd1: begin
				if (occ_a == 2'd0) begin
					slot0_d = push.r0;
				end else begin
					slot1_d = push.r0;
				end
			end
			2'd2: begin
				slot0_d = push.r0;
				slot1_d = push.r1;
			end
			default: ;
		endcase
		occ_d = occ_a + push.count;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= 2'd0;
		end else begin
			occ_q <= occ_d;
		end
	end

	always_ff @(posedge clk) begin
		slot0_q <= slot0_d;
		slot1_q <= slot1_d;
	end

endmodule

// ===== rtl/speech_segment_endpointer_top.sv =====
// Speech segment endpointer: top level joining registers, tracker and result buffer.
// A taken window item waits in the input register, then its results go into the buffer;
// throughput is one item per cycle while the buffer can take two results, so an item with
// two results holds up the next one until the buffer can take two results again.
// Reset (arst_n low, asynchronous): registers return to their defaults, segment state
// clears, numbering restarts at 1, and no result is pending.
module speech_segment_endpointer_top (
	input logic       clk,
	input logic       arst_n,
	sse_in_if.sink    window,
	sse_out_if.source request,
	sse_cfg_if.sink   cfg
);

	// register bank; the user writes it only while the block is idle, the block does not enforce it
	sse_pkg::cfg_t  regs;
	// results of the item committed this cycle
	sse_pkg::push_t push;
	// buffer can take two results this cycle
	logic           room2;

	sse_cfg_regs u_cfg_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (cfg),
		.regs   (regs)
	);

	// Input register plus the whole per-window step: pre-roll fill, open,
	// growth, partial cadence, silence endpoint with post-roll trim, length cap.
	sse_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.window (window),
		.cfg    (regs),
		.room2  (room2),
		.push   (push)
	);

	// A partial and a close can come from the same window; both land here and
	// leave one per cycle while the receiver is ready, the close carrying last.
	sse_out_buf u_out_buf (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.room2   (room2),
		.request (request)
	);

endmodule

// ===== rtl/sse_checker.sv =====
// Port-level checks on the endpointer's request channel, bound to the top level.
`include "speech_segment_endpointer_top_macros.svh"

module sse_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        req_valid,
	input logic        req_ready,
	input logic [1:0]  req_kind,
	input logic [31:0] req_num,
	input logic [47:0] req_start,
	input logic [47:0] req_end,
	input logic        req_last
);

	// whole payload of the head item
	logic [130:0] req_payload;
	logic         kind_known;

	assign req_payload = {req_kind, req_num, req_start, req_end, req_last};
	assign kind_known  = (req_kind == sse_pkg::KIND_PARTIAL) || (req_kind == sse_pkg::KIND_FINAL)
		|| (req_kind == sse_pkg::KIND_DISCARD);

	`SSE_ASSERT_NEXT(a_req_hold, req_valid && !req_ready, req_valid)
	`SSE_ASSERT_NEXT(a_req_stable, req_valid && !req_ready, $stable(req_payload))
	`SSE_ASSERT_NOW(a_kind_code, req_valid, kind_known)
	`SSE_ASSERT_NOW(a_close_is_last, req_valid && req_kind != sse_pkg::KIND_PARTIAL, req_last)
	`SSE_ASSERT_NEXT(a_pair_follows, req_valid && req_ready && !req_last, req_valid)

endmodule

bind speech_segment_endpointer_top sse_checker u_sse_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (request.valid),
	.req_ready (request.ready),
	.req_kind  (request.request_kind),
	.req_num   (request.segment_number),
	.req_start (request.span_first),
	.req_end   (request.span_limit),
	.req_last  (request.last)
);

// ===== tb/speech_segment_endpointer_checker.sv =====
`timescale 1ns / 100ps
// Scoreboard for the endpointer: predicts requests from accepted windows and checks them.
module speech_segment_endpointer_checker (
	input  logic        clk,
	input  logic        arst_n,
	sse_in_if           window,
	sse_out_if          request,
	sse_cfg_if          cfg,
	output int unsigned mismatches,
	output int unsigned awaiting
);

	sse_pkg::cfg_t regs;
	logic          seg_open;
	logic [31:0]   seg_number;
	logic [31:0]   next_number;
	logic [47:0]   seg_start;
	logic [24:0]   seg_len;
	logic [23:0]   speech_run;
	logic [23:0]   silence_run;
	logic [47:0]   partial_mark;
	logic [23:0]   preroll;
	sse_pkg::res_t due_requests[$];

	function automatic logic [23:0] sat24(input logic [24:0] sum);
		return sum[24] ? 24'hFFFFFF : sum[23:0];
	endfunction

	function automatic void clear_tracking();
		seg_open     = 1'b0;
		seg_number   = '0;
		next_number  = 32'd1;
		seg_start    = '0;
		seg_len      = '0;
		speech_run   = '0;
		silence_run  = '0;
		partial_mark = '0;
		preroll      = '0;
	endfunction

	function automatic void queue_request(input logic [1:0] kind);
		sse_pkg::res_t r;
		r.request_kind   = kind;
		r.segment_number = seg_number;
		r.span_first     = seg_start;
		r.span_limit     = seg_start + 48'(seg_len);
		r.last           = 1'b0;
		due_requests.insert(due_requests.size(), r);
	endfunction

	// closes the open segment as final or discarded; numbering moves on only when kept
	function automatic void close_segment();
		if (!seg_open)
			return;
		if (speech_run < regs.min_speech_samples) begin
			queue_request(sse_pkg::KIND_DISCARD);
		end else begin
			queue_request(sse_pkg::KIND_FINAL);
			next_number  = seg_number + 32'd1;
			partial_mark = '0;
		end
		seg_open    = 1'b0;
		seg_len     = '0;
		speech_run  = '0;
		silence_run = '0;
	endfunction

	function automatic void track_item(input logic [1:0] cmd, input logic [15:0] prob,
		input logic [47:0] wstart);
		int unsigned   queued;
		logic [48:0]   wend;
		logic [48:0]   span_end;
		logic [24:0]   fill_next;
		logic [25:0]   grown;
		logic [24:0]   excess;
		sse_pkg::res_t tail;
		queued = due_requests.size();
		case (cmd)
			sse_pkg::CMD_RESET: clear_tracking();
			sse_pkg::CMD_END: begin
				close_segment();
				clear_tracking();
			end
			sse_pkg::CMD_WINDOW: begin
				wend      = {1'b0, wstart} + 49'(sse_pkg::WINDOW_SAMPLES);
				fill_next = {1'b0, preroll} + 25'(sse_pkg::WINDOW_SAMPLES);
				preroll   = (fill_next > {1'b0, regs.pre_roll_len}) ? regs.pre_roll_len
					: fill_next[23:0];
				grown     = {1'b0, seg_len} + 26'(sse_pkg::WINDOW_SAMPLES);
				if (prob >= regs.voice_level) begin
					if (!seg_open) begin
						seg_open     = 1'b1;
						seg_number   = next_number;
						seg_start    = (wend > 49'(preroll)) ? 48'(wend - 49'(preroll)) : '0;
						seg_len      = 25'(preroll);
						partial_mark = seg_start;
					end else begin
						seg_len = grown[25] ? '1 : grown[24:0];
					end
					speech_run  = sat24({1'b0, speech_run} + 25'(sse_pkg::WINDOW_SAMPLES));
					silence_run = '0;
				end else if (seg_open) begin
					seg_len     = grown[25] ? '1 : grown[24:0];
					silence_run = sat24({1'b0, silence_run} + 25'(sse_pkg::WINDOW_SAMPLES));
				end
				if (seg_open) begin
					span_end = {1'b0, seg_start} + 49'(seg_len);
					if (seg_len >= 25'(regs.min_partial_len)
						&& span_end >= {1'b0, partial_mark}
						&& span_end - {1'b0, partial_mark} >= 49'(regs.partial_cadence)) begin
						queue_request(sse_pkg::KIND_PARTIAL);
						partial_mark = span_end[47:0];
					end
					if (silence_run >= regs.endpoint_silence) begin
						// trim trailing silence down to the post-roll
						if (silence_run > regs.post_roll_len) begin
							excess = {1'b0, silence_run - regs.post_roll_len};
							if (excess <= seg_len)
								seg_len = seg_len - excess;
						end
						close_segment();
					end else if (seg_len >= 25'(regs.max_segment_len)) begin
						close_segment();
					end
				end
			end
			default: ;
		endcase
		if (due_requests.size() > queued) begin
			tail      = due_requests[due_requests.size() - 1];
			tail.last = 1'b1;
			due_requests[due_requests.size() - 1] = tail;
		end
	endfunction

	function automatic void compare_field(input string field, input logic [47:0] want,
		input logic [47:0] seen);
		if (seen !== want) begin
			mismatches++;
			$error("%s mismatch: expected %0d, got %0d", field, want, seen);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin : tracker
		sse_pkg::res_t seen;
		sse_pkg::res_t want;
		if (!arst_n) begin
			regs = sse_pkg::CFG_RESET;
			clear_tracking();
			due_requests.delete();
		end else begin
			if (request.valid && request.ready) begin
				seen = '{request.request_kind, request.segment_number, request.span_first,
					request.span_limit, request.last};
				if (due_requests.size() == 0) begin
					mismatches++;
					$error("unexpected request: kind %0d, segment %0d", seen.request_kind,
						seen.segment_number);
				end else begin
					want = due_requests[0];
					due_requests.delete(0);
					compare_field("request_kind", 48'(want.request_kind), 48'(seen.request_kind));
					compare_field("segment_number", 48'(want.segment_number),
						48'(seen.segment_number));
					compare_field("span_first", want.span_first, seen.span_first);
					compare_field("span_limit", want.span_limit, seen.span_limit);
					compare_field("last", 48'(want.last), 48'(seen.last));
				end
			end
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					sse_pkg::REG_VOICE_LEVEL:        regs.voice_level        = cfg.data[15:0];
					sse_pkg::REG_MIN_SPEECH_SAMPLES: regs.min_speech_samples = cfg.data;
					sse_pkg::REG_ENDPOINT_SILENCE:   regs.endpoint_silence   = cfg.data;
					sse_pkg::REG_PRE_ROLL_LEN:       regs.pre_roll_len       = cfg.data;
					sse_pkg::REG_POST_ROLL_LEN:      regs.post_roll_len      = cfg.data;
					sse_pkg::REG_MAX_SEGMENT_LEN:    regs.max_segment_len    = cfg.data;
					sse_pkg::REG_MIN_PARTIAL_LEN:    regs.min_partial_len    = cfg.data;
					sse_pkg::REG_PARTIAL_CADENCE:    regs.partial_cadence    = cfg.data;
					default: ;
				endcase
			end
			if (window.valid && window.ready)
				track_item(window.command, window.speech_probability, window.win_origin);
		end
		awaiting = due_requests.size();
	end

endmodule

// ===== tb/speech_segment_endpointer_top_tb.sv =====
`timescale 1ns / 100ps
// Testbench top: drives windows and register writes into the endpointer and gives the verdict.
module speech_segment_endpointer_top_tb;

	// command code the block must ignore
	localparam logic [1:0] CMD_SPARE = 2'd3;
	// cycles allowed after the last request for an item still in flight
	localparam int unsigned SETTLE_CYCLES = 4;
	localparam int unsigned PHASE_ITEMS   = 56;

	typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

	logic        clk;
	logic        arst_n;
	int unsigned mismatches;
	int unsigned awaiting;
	int unsigned send_idle_pct;
	int unsigned recv_stall_pct;
	logic [15:0] cur_threshold;  // threshold as the block sees it, after masking
	logic [47:0] next_start;     // start of the next window in a well-formed stream
	logic        talking;

	sse_in_if  window();
	sse_out_if request();
	sse_cfg_if cfg();

	speech_segment_endpointer_top dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.window  (window),
		.request (request),
		.cfg     (cfg)
	);

	speech_segment_endpointer_checker scoreboard (
		.clk        (clk),
		.arst_n     (arst_n),
		.window     (window),
		.request    (request),
		.cfg        (cfg),
		.mismatches (mismatches),
		.awaiting   (awaiting)
	);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// receiver back-pressure, redrawn every cycle
	always @(negedge clk) begin
		request.ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// hard stop if the run hangs
	initial begin
		#8_000_000;
		$display("simulation failed");
		$finish;
	end

	task automatic set_idle(input idle_mode_t mode);
		case (mode)
			IDLE_NONE: begin
				send_idle_pct  = 0;
				recv_stall_pct = 0;
			end
			IDLE_SENDER: begin
				send_idle_pct  = 78;
				recv_stall_pct = 0;
			end
			IDLE_RECEIVER: begin
				send_idle_pct  = 0;
				recv_stall_pct = 78;
			end
			default: begin
				send_idle_pct  = 37;
				recv_stall_pct = 37;
			end
		endcase
	endtask

	// Offers one item from a falling edge and returns at the falling edge after it is taken.
	// Valid stays high on return so back-to-back items never drop it.
	task automatic send_item(input logic [1:0] cmd, input logic [15:0] prob,
		input logic [47:0] wstart);
		while ($urandom_range(99) < send_idle_pct) begin
			// idle cycle: payload is junk and must be ignored
			window.valid              <= 1'b0;
			window.command            <= 2'($urandom);
			window.speech_probability <= 16'($urandom);
			window.win_origin         <= 48'({$urandom, $urandom});
			@(negedge clk);
		end
		window.valid              <= 1'b1;
		window.command            <= cmd;
		window.speech_probability <= prob;
		window.win_origin         <= wstart;
		do @(posedge clk); while (!window.ready);
		@(negedge clk);
	endtask

	// Sender holds off until every expected request has come, then lets the pipe settle.
	task automatic drain();
		window.valid <= 1'b0;
		while (awaiting != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// leaves valid high; the caller drops it after the last write
	task automatic cfg_write(input logic [sse_pkg::CFG_IDX_W-1:0] idx, input logic [23:0] val);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data  <= val;
		do @(posedge clk); while (!cfg.ready);
		@(negedge clk);
	endtask

	// Rewrites the whole register map, plus one write to an unmapped index that must be ignored.
	task automatic set_regs(input logic [23:0] thr, input logic [23:0] min_speech,
		input logic [23:0] endpoint, input logic [23:0] pre_roll, input logic [23:0] post_roll,
		input logic [23:0] max_len, input logic [23:0] min_partial, input logic [23:0] cadence);
		cfg_write(sse_pkg::REG_VOICE_LEVEL, thr);
		cfg_write(sse_pkg::REG_MIN_SPEECH_SAMPLES, min_speech);
		cfg_write(sse_pkg::REG_ENDPOINT_SILENCE, endpoint);
		cfg_write(sse_pkg::REG_PRE_ROLL_LEN, pre_roll);
		cfg_write(sse_pkg::REG_POST_ROLL_LEN, post_roll);
		cfg_write(sse_pkg::REG_MAX_SEGMENT_LEN, max_len);
		cfg_write(sse_pkg::REG_MIN_PARTIAL_LEN, min_partial);
		cfg_write(sse_pkg::REG_PARTIAL_CADENCE, cadence);
		cfg_write(sse_pkg::CFG_IDX_W'($urandom_range(255, sse_pkg::REG_PARTIAL_CADENCE + 1)),
			24'($urandom));
		cfg.valid     <= 1'b0;
		cur_threshold = thr[15:0];
	endtask

	// Mostly a contiguous window stream alternating talk and pause bursts; the rest is
	// end-of-stream, resets, the spare code and windows at random positions.
	task automatic random_item();
		int unsigned pick;
		logic [15:0] prob;
		pick = $urandom_range(99);
		if (pick < 2) begin
			send_item(sse_pkg::CMD_END, 16'($urandom), 48'({$urandom, $urandom}));
		end else if (pick < 4) begin
			send_item(sse_pkg::CMD_RESET, 16'($urandom), 48'({$urandom, $urandom}));
		end else if (pick < 5) begin
			send_item(CMD_SPARE, 16'($urandom), 48'({$urandom, $urandom}));
		end else if (pick < 9) begin
			next_start = 48'({$urandom, $urandom});
			send_item(sse_pkg::CMD_WINDOW, 16'($urandom), next_start);
			next_start += 48'(sse_pkg::WINDOW_SAMPLES);
		end else begin
			if (talking ? ($urandom_range(4) == 0) : ($urandom_range(5) == 0))
				talking = !talking;
			if (talking)
				prob = 16'($urandom_range(65535, cur_threshold));
			else if (cur_threshold == 16'd0)
				prob = 16'($urandom);
			else
				prob = 16'($urandom_range(cur_threshold - 1, 0));
			send_item(sse_pkg::CMD_WINDOW, prob, next_start);
			next_start += 48'(sse_pkg::WINDOW_SAMPLES);
		end
	endtask

	task automatic run_phase(input idle_mode_t mode);
		set_idle(mode);
		repeat (PHASE_ITEMS) begin
			random_item();
			// now and then the sender waits for every request to come out
			if ($urandom_range(39) == 0)
				drain();
		end
		drain();
	endtask

	initial begin
		arst_n                    = 1'b0;
		window.valid              = 1'b0;
		window.command            = sse_pkg::CMD_WINDOW;
		window.speech_probability = '0;
		window.win_origin         = '0;
		cfg.valid                 = 1'b0;
		cfg.index                 = sse_pkg::REG_VOICE_LEVEL;
		cfg.data                  = '0;
		send_idle_pct             = 0;
		recv_stall_pct            = 0;
		cur_threshold             = sse_pkg::CFG_RESET.voice_level;
		next_start                = '0;
		talking                   = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed items on the reset register values
		send_item(CMD_SPARE, 16'hFFFF, '1);            // spare code: no request
		send_item(sse_pkg::CMD_RESET, '0, '0);         // reset with nothing open
		send_item(sse_pkg::CMD_END, '0, '0);           // end of stream with nothing open
		// pauses at zero and just under the threshold fill the pre-roll
		for (int i = 0; i < 9; i++)
			send_item(sse_pkg::CMD_WINDOW,
				(i % 2) ? sse_pkg::CFG_RESET.voice_level - 16'd1 : 16'd0,
				48'd1000000 + 48'(i * sse_pkg::WINDOW_SAMPLES));
		// speech exactly at threshold near sample zero: pre-roll start clamps to zero
		send_item(sse_pkg::CMD_WINDOW, sse_pkg::CFG_RESET.voice_level, '0);
		send_item(sse_pkg::CMD_END, '0, '0);           // too little speech: discarded
		// segment straddling the top of the sample index, kept on end of stream
		next_start = '1;
		repeat (8) begin
			send_item(sse_pkg::CMD_WINDOW, 16'hFFFF, next_start);
			next_start += 48'(sse_pkg::WINDOW_SAMPLES);
		end
		send_item(sse_pkg::CMD_END, '0, '0);
		drain();

		// random phases over a spread of register settings
		run_phase(IDLE_NONE);
		set_regs(24'h8000, 24'd1024, 24'd1536, 24'd1000, 24'd700, 24'd6000, 24'd1500,
			24'd1024);
		run_phase(IDLE_SENDER);
		// lowest values: every pause closes, every growth is a partial
		set_regs(24'd1, 24'd1, 24'd1, 24'd0, 24'd0, 24'd1, 24'd1, 24'd1);
		run_phase(IDLE_RECEIVER);
		// highest values, threshold written wider than its register
		set_regs('1, '1, '1, '1, '1, '1, '1, '1);
		run_phase(IDLE_BOTH);
		// threshold masks to zero so all is speech; stream wraps the sample index
		next_start = 48'hFFFF_FFFF_D800;
		set_regs(24'h010000, 24'd2048, 24'd512, '1, 24'd300, 24'd4096, 24'd1024, 24'd700);
		run_phase(IDLE_NONE);
		// post-roll longer than the endpoint silence: no trimming
		set_regs(24'($urandom_range(65535, 1)), 24'd512, 24'd2048, 24'd600, 24'd2500,
			24'd20000, 24'd3000, 24'd2000);
		run_phase(IDLE_BOTH);
		set_regs(24'(sse_pkg::CFG_RESET.voice_level), sse_pkg::CFG_RESET.min_speech_samples,
			sse_pkg::CFG_RESET.endpoint_silence, sse_pkg::CFG_RESET.pre_roll_len,
			sse_pkg::CFG_RESET.post_roll_len, sse_pkg::CFG_RESET.max_segment_len,
			sse_pkg::CFG_RESET.min_partial_len, sse_pkg::CFG_RESET.partial_cadence);
		run_phase(IDLE_RECEIVER);

		if (mismatches == 0 && awaiting == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
